FILE: sv/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, branch codes, control structs and saturation for the
// rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  // Fixed point format and field width
  localparam int FRAC_BITS = 14;
  localparam int IN_W      = 16;

  // Signed numerators and their magnitudes (sum or difference of two fields)
  localparam int NUM_W = IN_W + 1;
  localparam int MAG_W = IN_W + 1;

  // Trace and radicand arithmetic
  localparam int SUM_W  = ((FRAC_BITS > IN_W + 1) ? FRAC_BITS : IN_W + 1) + 3;
  localparam int RADM_W = SUM_W - 1;

  // Bits resolved per pipeline stage in the root and divide units
  localparam int STEP = 4;

  // Square root: root width padded to a whole number of stages
  localparam int ROOT_W    = ((RADM_W + FRAC_BITS + 1) / 2 + STEP - 1) / STEP * STEP;
  localparam int SQ_IN_W   = 2 * ROOT_W;
  localparam int SQ_STAGES = ROOT_W / STEP;

  // Divide: dividend is (mag << FRAC_BITS) + root, padded the same way
  localparam int DEN_W      = ROOT_W + 1;
  localparam int DVD_W      = ((MAG_W + FRAC_BITS + 1) + STEP - 1) / STEP * STEP;
  localparam int DIV_STAGES = DVD_W / STEP;

  // Prep, root stages, divisor prep, divide stages, output register
  localparam int NST = SQ_STAGES + DIV_STAGES + 3;

  localparam logic signed [SUM_W-1:0] ONE_S = SUM_W'(1) <<< FRAC_BITS;

  // Branch codes
  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  // Saturation limits as magnitudes
  localparam logic [DVD_W-1:0] POS_LIM = DVD_W'((1 << (IN_W - 1)) - 1);
  localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(1 << (IN_W - 1));
  localparam logic signed [IN_W-1:0] OUT_MAX = {1'b0, {(IN_W - 1){1'b1}}};
  localparam logic signed [IN_W-1:0] OUT_MIN = {1'b1, {(IN_W - 1){1'b0}}};

  // Control carried through the root stages
  typedef struct packed {
    logic [1:0]              branch;
    logic signed [NUM_W-1:0] na;
    logic signed [NUM_W-1:0] nb;
    logic signed [NUM_W-1:0] nc;
  } num_ctl_t;

  // Control carried through the divide stages
  typedef struct packed {
    logic [1:0]        branch;
    logic [2:0]        neg;
    logic [ROOT_W-1:0] half;
  } div_ctl_t;

  // Apply sign to a magnitude and clamp to the output range
  function automatic logic signed [IN_W-1:0] sat_mag(input logic neg,
                                                     input logic [DVD_W-1:0] mag);
    logic [DVD_W-1:0] neg_mag;
    neg_mag = -mag;
    if (!neg) begin
      return (mag > POS_LIM) ? OUT_MAX : mag[IN_W-1:0];
    end
    return (mag > NEG_LIM) ? OUT_MIN : neg_mag[IN_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/rmq_if.sv
// ----------------------------------------------------------------------------
// rmq_if
// Valid/ready channels: one beat carries a rotation matrix or a quaternion.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmq_pose_if;
  logic                                valid;
  logic                                ready;
  logic signed [rmq_pkg::IN_W-1:0]     right_x;
  logic signed [rmq_pkg::IN_W-1:0]     right_z;
  logic signed [rmq_pkg::IN_W-1:0]     right_y;
  logic signed [rmq_pkg::IN_W-1:0]     forward_x;
  logic signed [rmq_pkg::IN_W-1:0]     forward_z;
  logic signed [rmq_pkg::IN_W-1:0]     forward_y;
  logic signed [rmq_pkg::IN_W-1:0]     up_x;
  logic signed [rmq_pkg::IN_W-1:0]     up_z;
  logic signed [rmq_pkg::IN_W-1:0]     up_y;

  modport source (output valid, right_x, right_z, right_y, forward_x, forward_z,
                  forward_y, up_x, up_z, up_y, input ready);
  modport sink (input valid, right_x, right_z, right_y, forward_x, forward_z,
                forward_y, up_x, up_z, up_y, output ready);
endinterface

interface rmq_quat_if;
  logic                                valid;
  logic                                ready;
  logic signed [rmq_pkg::IN_W-1:0]     part_x;
  logic signed [rmq_pkg::IN_W-1:0]     part_z;
  logic signed [rmq_pkg::IN_W-1:0]     part_y;
  logic signed [rmq_pkg::IN_W-1:0]     part_w;

  modport source (output valid, part_x, part_z, part_y, part_w, input ready);
  modport sink (input valid, part_x, part_z, part_y, part_w, output ready);
endinterface

`default_nettype wire

FILE: sv/rmq_div_lane.sv
// ----------------------------------------------------------------------------
// rmq_div_lane
// Pipelined restoring divider: STEP quotient bits per stage, each stage
// advancing on its own enable.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div_lane (
  input  wire logic                              clk,
  input  wire logic [rmq_pkg::DIV_STAGES-1:0]    en,
  input  wire logic [rmq_pkg::DVD_W-1:0]         dvd,
  input  wire logic [rmq_pkg::DEN_W-1:0]         den,
  output logic      [rmq_pkg::DVD_W-1:0]         quo
);
  import rmq_pkg::*;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DVD_W-1:0] num;
    logic [DVD_W-1:0] quo;
    logic [DEN_W-1:0] den;
  } div_t;

  // Resolve STEP quotient bits
  function automatic div_t div_step(input div_t s);
    div_t           r;
    logic [DEN_W:0] t;
    r = s;
    for (int i = 0; i < STEP; i++) begin
      t     = {r.rem, r.num[DVD_W-1]};
      r.num = r.num << 1;
      if (t >= {1'b0, r.den}) begin
        t     = t - {1'b0, r.den};
        r.quo = {r.quo[DVD_W-2:0], 1'b1};
      end else begin
        r.quo = {r.quo[DVD_W-2:0], 1'b0};
      end
      r.rem = t[DEN_W-1:0];
    end
    return r;
  endfunction

  div_t init;
  div_t stg_d [DIV_STAGES];
  div_t stg_q [DIV_STAGES];

  // Build the next value of every stage
  always_comb begin
    init.rem = '0;
    init.num = dvd;
    init.quo = '0;
    init.den = den;
    stg_d[0] = div_step(init);
    for (int l = 1; l < DIV_STAGES; l++) begin
      stg_d[l] = div_step(stg_q[l-1]);
    end
  end

  // Advance stages that are free
  always_ff @(posedge clk) begin
    for (int l = 0; l < DIV_STAGES; l++) begin
      if (en[l]) begin
        stg_q[l] <= stg_d[l];
      end
    end
  end

  assign quo = stg_q[DIV_STAGES-1].quo;

endmodule

`default_nettype wire

FILE: sv/rotation_matrix_to_quaternion.sv
// Pipeline: prep, root stages, divisor prep, divide stages, output register.
// Throughput: one beat per cycle while the output is not stalled; each stage has its own valid bit, so
// bubbles collapse and a stalled output holds only the stages behind it.
// The square root and the three divides resolve four bits per stage.
// Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd conversion of a rotation matrix to a saturated Q2.14 quaternion.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion (
  input  wire logic   clk,
  input  wire logic   rst,
  rmq_pose_if.sink    pose,
  rmq_quat_if.source  quat
);
  import rmq_pkg::*;

  localparam int D_IDX   = SQ_STAGES + 1;
  localparam int DV0_IDX = SQ_STAGES + 2;

  typedef struct packed {
    logic [SQ_IN_W-1:0] rad;
    logic [ROOT_W:0]    rem;
    logic [ROOT_W-1:0]  root;
  } sq_t;

  // Resolve STEP root bits
  function automatic sq_t sq_step(input sq_t s);
    sq_t             r;
    logic [ROOT_W+2:0] t;
    logic [ROOT_W+2:0] trial;
    r = s;
    for (int i = 0; i < STEP; i++) begin
      t     = {r.rem, r.rad[SQ_IN_W-1 -: 2]};
      trial = {1'b0, r.root, 2'b01};
      r.rad = r.rad << 2;
      if (t >= trial) begin
        t      = t - trial;
        r.root = {r.root[ROOT_W-2:0], 1'b1};
      end else begin
        r.root = {r.root[ROOT_W-2:0], 1'b0};
      end
      r.rem = t[ROOT_W:0];
    end
    return r;
  endfunction

  // Stage valid bits and enables
  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld[NST-1] || quat.ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign pose.ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= pose.valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---- Stage 0: trace test, branch, radicand, numerators ----
  logic signed [SUM_W-1:0] e00, e11, e22, tr, rad_s;
  logic signed [NUM_W-1:0] m10, m20, m01, m21, m02, m12;
  num_ctl_t                a_ctl_next;
  logic [RADM_W-1:0]       a_rad_next;

  always_comb begin
    m20 = NUM_W'(pose.right_z);
    m10 = NUM_W'(pose.right_y);
    m02 = NUM_W'(pose.forward_x);
    m12 = NUM_W'(pose.forward_y);
    m01 = NUM_W'(pose.up_x);
    m21 = NUM_W'(pose.up_z);
    e00 = SUM_W'(pose.right_x);
    e11 = SUM_W'(pose.up_y);
    e22 = SUM_W'(pose.forward_z);
    tr  = e00 + e11 + e22;
    if (tr > 0) begin
      a_ctl_next.branch = BR_TRACE;
      rad_s         = tr + ONE_S;
      a_ctl_next.na = m21 - m12;
      a_ctl_next.nb = m02 - m20;
      a_ctl_next.nc = m10 - m01;
    end else if (e00 > e11 && e00 > e22) begin
      a_ctl_next.branch = BR_X;
      rad_s         = ONE_S + e00 - e11 - e22;
      a_ctl_next.na = m21 - m12;
      a_ctl_next.nb = m01 + m10;
      a_ctl_next.nc = m02 + m20;
    end else if (e11 > e22) begin
      a_ctl_next.branch = BR_Y;
      rad_s         = ONE_S + e11 - e00 - e22;
      a_ctl_next.na = m02 - m20;
      a_ctl_next.nb = m01 + m10;
      a_ctl_next.nc = m12 + m21;
    end else begin
      a_ctl_next.branch = BR_Z;
      rad_s         = ONE_S + e22 - e00 - e11;
      a_ctl_next.na = m10 - m01;
      a_ctl_next.nb = m02 + m20;
      a_ctl_next.nc = m12 + m21;
    end
    // Clamp a non-positive radicand to one LSB
    a_rad_next = (rad_s <= 0) ? RADM_W'(1) : rad_s[RADM_W-1:0];
  end

  num_ctl_t          a_ctl;
  logic [RADM_W-1:0] a_rad;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      a_ctl <= a_ctl_next;
      a_rad <= a_rad_next;
    end
  end

  // ---- Square root stages ----
  sq_t      sq_init;
  sq_t      sq_d [SQ_STAGES];
  sq_t      sq_q [SQ_STAGES];
  num_ctl_t sq_ctl [SQ_STAGES];

  always_comb begin
    sq_init.rad  = SQ_IN_W'(a_rad) << FRAC_BITS;
    sq_init.rem  = '0;
    sq_init.root = '0;
    sq_d[0]      = sq_step(sq_init);
    for (int s = 1; s < SQ_STAGES; s++) begin
      sq_d[s] = sq_step(sq_q[s-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sq_q[0]   <= sq_d[0];
      sq_ctl[0] <= a_ctl;
    end
    for (int s = 1; s < SQ_STAGES; s++) begin
      if (en[s+1]) begin
        sq_q[s]   <= sq_d[s];
        sq_ctl[s] <= sq_ctl[s-1];
      end
    end
  end

  // ---- Divisor and dividends ----
  num_ctl_t          r_ctl;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W:0]   root_inc;
  logic [MAG_W-1:0]  mag_a, mag_b, mag_c;
  div_ctl_t          d_ctl_next;

  always_comb begin
    r_ctl    = sq_ctl[SQ_STAGES-1];
    root     = (sq_q[SQ_STAGES-1].root == '0) ? ROOT_W'(1) : sq_q[SQ_STAGES-1].root;
    root_inc = {1'b0, root} + 1'b1;
    d_ctl_next.branch = r_ctl.branch;
    d_ctl_next.neg    = {r_ctl.nc[NUM_W-1], r_ctl.nb[NUM_W-1], r_ctl.na[NUM_W-1]};
    d_ctl_next.half   = root_inc[ROOT_W:1];
    mag_a = r_ctl.na[NUM_W-1] ? MAG_W'(-r_ctl.na) : MAG_W'(r_ctl.na);
    mag_b = r_ctl.nb[NUM_W-1] ? MAG_W'(-r_ctl.nb) : MAG_W'(r_ctl.nb);
    mag_c = r_ctl.nc[NUM_W-1] ? MAG_W'(-r_ctl.nc) : MAG_W'(r_ctl.nc);
  end

  div_ctl_t         d_ctl;
  logic [DEN_W-1:0] d_den;
  logic [DVD_W-1:0] d_dvd_a, d_dvd_b, d_dvd_c;

  // Dividend adds den/2 (= root) for round to nearest
  always_ff @(posedge clk) begin
    if (en[D_IDX]) begin
      d_ctl   <= d_ctl_next;
      d_den   <= {root, 1'b0};
      d_dvd_a <= (DVD_W'(mag_a) << FRAC_BITS) + DVD_W'(root);
      d_dvd_b <= (DVD_W'(mag_b) << FRAC_BITS) + DVD_W'(root);
      d_dvd_c <= (DVD_W'(mag_c) << FRAC_BITS) + DVD_W'(root);
    end
  end

  // ---- Divide stages ----
  logic [DIV_STAGES-1:0] div_en;
  logic [DVD_W-1:0]      q_a, q_b, q_c;
  div_ctl_t              dv_ctl [DIV_STAGES];

  assign div_en = en[DV0_IDX +: DIV_STAGES];

  rmq_div_lane u_div_a (.clk(clk), .en(div_en), .dvd(d_dvd_a), .den(d_den), .quo(q_a));
  rmq_div_lane u_div_b (.clk(clk), .en(div_en), .dvd(d_dvd_b), .den(d_den), .quo(q_b));
  rmq_div_lane u_div_c (.clk(clk), .en(div_en), .dvd(d_dvd_c), .den(d_den), .quo(q_c));

  always_ff @(posedge clk) begin
    if (div_en[0]) begin
      dv_ctl[0] <= d_ctl;
    end
    for (int l = 1; l < DIV_STAGES; l++) begin
      if (div_en[l]) begin
        dv_ctl[l] <= dv_ctl[l-1];
      end
    end
  end

  // ---- Output: sign, saturate, place components ----
  div_ctl_t                f_ctl;
  logic signed [IN_W-1:0]  s_a, s_b, s_c, s_h;
  logic signed [IN_W-1:0]  x_next, y_next, z_next, w_next;

  always_comb begin
    f_ctl = dv_ctl[DIV_STAGES-1];
    s_a   = sat_mag(f_ctl.neg[0], q_a);
    s_b   = sat_mag(f_ctl.neg[1], q_b);
    s_c   = sat_mag(f_ctl.neg[2], q_c);
    s_h   = sat_mag(1'b0, DVD_W'(f_ctl.half));
    case (f_ctl.branch)
      BR_TRACE: begin
        x_next = s_a; y_next = s_b; z_next = s_c; w_next = s_h;
      end
      BR_X: begin
        x_next = s_h; y_next = s_b; z_next = s_c; w_next = s_a;
      end
      BR_Y: begin
        x_next = s_b; y_next = s_h; z_next = s_c; w_next = s_a;
      end
      default: begin
        x_next = s_b; y_next = s_c; z_next = s_h; w_next = s_a;
      end
    endcase
  end

  logic signed [IN_W-1:0] out_x, out_y, out_z, out_w;

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      out_x <= x_next;
      out_y <= y_next;
      out_z <= z_next;
      out_w <= w_next;
    end
  end

  assign quat.valid  = vld[NST-1];
  assign quat.part_x = out_x;
  assign quat.part_z = out_z;
  assign quat.part_y = out_y;
  assign quat.part_w = out_w;

`ifndef SYNTH
  // An accepted beat always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    pose.valid && pose.ready |=> vld[0])
    else $error("accepted beat not captured in stage 0");

  // Clamped radicand is never zero
  a_rad_nonzero: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> a_rad != '0)
    else $error("radicand reached zero");

  // Root out of the last root stage is never zero
  a_root_nonzero: assert property (@(posedge clk) disable iff (rst)
    vld[SQ_STAGES] |-> sq_q[SQ_STAGES-1].root != '0)
    else $error("square root result is zero");

  // An empty output stage lets the whole pipe move
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !quat.valid |-> pose.ready)
    else $error("input stalled with output stage empty");

  // A full pipe behind a stalled output takes nothing
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (&vld) && !quat.ready |-> !pose.ready)
    else $error("input accepted while pipe full and stalled");
`endif

endmodule

`default_nettype wire

FILE: tb/rotation_matrix_to_quaternion_test.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_test
// Drives rotation matrices through the pose channel with random gaps and
// output stalls, predicts each quaternion with an integer Shepperd model and
// compares every returned beat in order.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion_test;
  import rmq_pkg::*;

  typedef logic signed [IN_W-1:0] fx_t;

  typedef struct {
    fx_t rx, rz, ry, fx, fz, fy, ux, uz, uy;
  } pose_t;

  typedef struct {
    fx_t px, pz, py, pw;
  } quat_t;

  // Directed row: pose, and a typed-in quaternion where it is obvious
  typedef struct {
    pose_t p;
    bit    known;
    quat_t q;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rmq_pose_if pose ();
  rmq_quat_if quat ();

  rotation_matrix_to_quaternion dut (
    .clk  (clk),
    .rst  (rst),
    .pose (pose.sink),
    .quat (quat.source)
  );

  always #6 clk = ~clk;

  quat_t quat_queue[$];
  int    errors = 0;
  bit    sending_done = 1'b0;
  row_t  rows[$];

  // Integer square root of a non-negative value
  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n   -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Fixed point divide, halves rounded away from zero
  function automatic longint quot_round(input longint num, input longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : num;
    q   = ((mag << FRAC_BITS) + (den >> 1)) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic fx_t clamp16(input longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return fx_t'(v);
  endfunction

  function automatic quat_t shepperd_quat(input pose_t p);
    longint m00, m20, m10, m02, m22, m12, m01, m21, m11, t, rad, qx, qy, qz, qw;
    longint unsigned root, den, half;
    logic [1:0] br;
    quat_t q;
    m00 = p.rx; m20 = p.rz; m10 = p.ry;
    m02 = p.fx; m22 = p.fz; m12 = p.fy;
    m01 = p.ux; m21 = p.uz; m11 = p.uy;
    t = m00 + m11 + m22;
    // Pick the branch: trace first, then the largest diagonal
    if (t > 0) begin
      br = BR_TRACE; rad = t + (64'sd1 << FRAC_BITS);
    end else if (m00 > m11 && m00 > m22) begin
      br = BR_X; rad = (64'sd1 << FRAC_BITS) + m00 - m11 - m22;
    end else if (m11 > m22) begin
      br = BR_Y; rad = (64'sd1 << FRAC_BITS) + m11 - m00 - m22;
    end else begin
      br = BR_Z; rad = (64'sd1 << FRAC_BITS) + m22 - m00 - m11;
    end
    if (rad <= 0) rad = 1;
    root = root_floor(longint'(rad) << FRAC_BITS);
    if (root == 0) root = 1;
    den  = root * 2;
    half = (root + 1) >> 1;
    case (br)
      BR_TRACE: begin
        qw = half;
        qx = quot_round(m21 - m12, den);
        qy = quot_round(m02 - m20, den);
        qz = quot_round(m10 - m01, den);
      end
      BR_X: begin
        qw = quot_round(m21 - m12, den);
        qx = half;
        qy = quot_round(m01 + m10, den);
        qz = quot_round(m02 + m20, den);
      end
      BR_Y: begin
        qw = quot_round(m02 - m20, den);
        qx = quot_round(m01 + m10, den);
        qy = half;
        qz = quot_round(m12 + m21, den);
      end
      default: begin
        qw = quot_round(m10 - m01, den);
        qx = quot_round(m02 + m20, den);
        qy = quot_round(m12 + m21, den);
        qz = half;
      end
    endcase
    q.px = clamp16(qx); q.pz = clamp16(qz); q.py = clamp16(qy); q.pw = clamp16(qw);
    return q;
  endfunction

  function automatic pose_t mk_pose(input int rx, rz, ry, fx, fz, fy, ux, uz, uy);
    pose_t p;
    p.rx = fx_t'(rx); p.rz = fx_t'(rz); p.ry = fx_t'(ry);
    p.fx = fx_t'(fx); p.fz = fx_t'(fz); p.fy = fx_t'(fy);
    p.ux = fx_t'(ux); p.uz = fx_t'(uz); p.uy = fx_t'(uy);
    return p;
  endfunction

  function automatic quat_t mk_quat(input int px, pz, py, pw);
    quat_t q;
    q.px = fx_t'(px); q.pz = fx_t'(pz); q.py = fx_t'(py); q.pw = fx_t'(pw);
    return q;
  endfunction

  function automatic fx_t rnd_fx();
    case ($urandom_range(0, 5))
      0: return fx_t'($urandom);
      1: return ($urandom_range(0, 1)) ? fx_t'(32767) : fx_t'(-32768);
      default: return fx_t'($urandom_range(0, 32768) - 16384);
    endcase
  endfunction

  // Random orthonormal-ish matrix: signed axis permutation with a small tilt
  function automatic pose_t rnd_rotation();
    int m[3][3];
    int perm[3];
    int a, b, c, e;
    pose_t p;
    perm = '{0, 1, 2};
    a = $urandom_range(0, 2); b = perm[a]; perm[a] = perm[2]; perm[2] = b;
    a = $urandom_range(0, 1); b = perm[a]; perm[a] = perm[1]; perm[1] = b;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        e = $urandom_range(0, 2000) - 1000;
        m[i][j] = (perm[i] == j) ? (($urandom_range(0, 1)) ? 16384 - e / 4 : e / 4 - 16384)
                                 : e;
      end
    c = $urandom_range(0, 1);
    p = mk_pose(m[0][0], m[2][0], m[1][0], m[0][2], m[2][2], m[1][2],
                m[0][1], m[2][1], m[1][1]);
    if (c) p.uy = -p.uy;
    return p;
  endfunction

  function automatic pose_t rnd_noise();
    return mk_pose(rnd_fx(), rnd_fx(), rnd_fx(), rnd_fx(), rnd_fx(), rnd_fx(),
                   rnd_fx(), rnd_fx(), rnd_fx());
  endfunction

  // Drive one pose beat and log its expected quaternion; valid stays high
  // after the beat so the next one can follow without a gap
  task automatic send_pose(input pose_t p);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      pose.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pose.valid     <= 1'b1;
    pose.right_x   <= p.rx; pose.right_z <= p.rz; pose.right_y <= p.ry;
    pose.forward_x <= p.fx; pose.forward_z <= p.fz; pose.forward_y <= p.fy;
    pose.up_x      <= p.ux; pose.up_z <= p.uz; pose.up_y <= p.uy;
    @(posedge clk);
    while (!pose.ready) @(posedge clk);
    quat_queue.push_back(shepperd_quat(p));
    @(negedge clk);
  endtask

  // Drop valid and hold off until every expected result has come
  task automatic drain_pose();
    pose.valid <= 1'b0;
    do @(negedge clk); while (quat_queue.size() != 0);
  endtask

  // Stimulus
  initial begin
    pose_t p;
    pose.valid = 1'b0;
    {pose.right_x, pose.right_z, pose.right_y, pose.forward_x, pose.forward_z,
     pose.forward_y, pose.up_x, pose.up_z, pose.up_y} = '0;
    // identity and half-turns about each axis
    rows.push_back('{mk_pose(16384, 0, 0, 0, 16384, 0, 0, 0, 16384), 1,
                     mk_quat(0, 0, 0, 16384)});
    rows.push_back('{mk_pose(16384, 0, 0, 0, -16384, 0, 0, 0, -16384), 1,
                     mk_quat(16384, 0, 0, 0)});
    rows.push_back('{mk_pose(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384), 1,
                     mk_quat(0, 0, 16384, 0)});
    rows.push_back('{mk_pose(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384), 1,
                     mk_quat(0, 16384, 0, 0)});
    // all zero: trace not positive, diagonal ties fall to the z branch
    rows.push_back('{mk_pose(0, 0, 0, 0, 0, 0, 0, 0, 0), 0, mk_quat(0, 0, 0, 0)});
    // all fields at the extremes
    rows.push_back('{mk_pose(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                     32767), 0, mk_quat(0, 0, 0, 0)});
    rows.push_back('{mk_pose(-32768, -32768, -32768, -32768, -32768, -32768, -32768,
                     -32768, -32768), 0, mk_quat(0, 0, 0, 0)});
    rows.push_back('{mk_pose(-32768, 32767, -32768, 32767, -32768, -32768, 32767,
                     32767, -32768), 0, mk_quat(0, 0, 0, 0)});
    // negative diagonals in a diagonal branch, numerators near their extremes
    rows.push_back('{mk_pose(-16384, 32767, -32768, 32767, -16385, -32768, 32767,
                     32767, -16385), 0, mk_quat(0, 0, 0, 0)});
    rows.push_back('{mk_pose(-30000, -32768, 32767, -32768, -30000, 32767, -32768,
                     -32768, -30001), 0, mk_quat(0, 0, 0, 0)});
    // ties between diagonal elements
    rows.push_back('{mk_pose(-100, 500, 200, 300, -100, 10, 20, 30, -100), 0,
                     mk_quat(0, 0, 0, 0)});
    rows.push_back('{mk_pose(-50, 500, 200, 300, -100, 10, 20, 30, -50), 0,
                     mk_quat(0, 0, 0, 0)});
    rows.push_back('{mk_pose(-50, 500, 200, 300, -50, 10, 20, 30, -100), 0,
                     mk_quat(0, 0, 0, 0)});
    // trace just at zero and just above
    rows.push_back('{mk_pose(1, 7, -7, 9, -1, 3, 4, -5, 0), 0, mk_quat(0, 0, 0, 0)});
    rows.push_back('{mk_pose(1, 7, -7, 9, 0, 3, 4, -5, 0), 0, mk_quat(0, 0, 0, 0)});
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (rows[i]) begin
      send_pose(rows[i].p);
      if (rows[i].known) quat_queue[$] = rows[i].q;
    end

    // Hold off until the pipe drains, then go random
    drain_pose();
    for (int n = 0; n < 600; n++) begin
      p = ($urandom_range(0, 3) == 0) ? rnd_noise() : rnd_rotation();
      send_pose(p);
      if (n == 300) drain_pose();
    end
    pose.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Output stalls, drawn once per beat
  initial begin
    int stall;
    quat.ready = 1'b0;
    @(negedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        quat.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      quat.ready <= 1'b1;
      @(posedge clk);
      while (!quat.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Compare each returned beat with the oldest prediction
  always @(posedge clk) begin
    quat_t want;
    if (!rst && quat.valid && quat.ready) begin
      if (quat_queue.size() == 0) begin
        $display("%0t: unexpected quaternion %0d %0d %0d %0d", $time,
                 quat.part_x, quat.part_z, quat.part_y, quat.part_w);
        errors++;
      end else begin
        want = quat_queue.pop_front();
        if (quat.part_x !== want.px) begin
          $display("%0t: part_x expected %0d actual %0d", $time, want.px, quat.part_x);
          errors++;
        end
        if (quat.part_z !== want.pz) begin
          $display("%0t: part_z expected %0d actual %0d", $time, want.pz, quat.part_z);
          errors++;
        end
        if (quat.part_y !== want.py) begin
          $display("%0t: part_y expected %0d actual %0d", $time, want.py, quat.part_y);
          errors++;
        end
        if (quat.part_w !== want.pw) begin
          $display("%0t: part_w expected %0d actual %0d", $time, want.pw, quat.part_w);
          errors++;
        end
      end
    end
  end

  // Drain, settle, report
  initial begin
    wait (sending_done);
    while (quat_queue.size() != 0) @(posedge clk);
    repeat (4 * NST) @(posedge clk);
    if (errors == 0 && quat_queue.size() == 0) begin
      $display("rotation_matrix_to_quaternion test passed");
    end else begin
      $display("rotation_matrix_to_quaternion test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("rotation_matrix_to_quaternion test failed");
    $finish;
  end

endmodule

`default_nettype wire
